// File: rtl/core/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

  // Operation codes carried by a request.
  localparam logic OP_START = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Reported phase codes.
  localparam logic [2:0] PHASE_PRECHARGE = 3'd0;
  localparam logic [2:0] PHASE_FAST      = 3'd1;
  localparam logic [2:0] PHASE_TRICKLE   = 3'd2;
  localparam logic [2:0] PHASE_FULL_HOLD = 3'd3;
  localparam logic [2:0] PHASE_HALTED    = 3'd4;

  // Shutdown cause codes.
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_COOLING  = 3'd1;
  localparam logic [2:0] CAUSE_FULL     = 3'd2;
  localparam logic [2:0] CAUSE_CHG_VOLT = 3'd3;
  localparam logic [2:0] CAUSE_CURRENT  = 3'd4;
  localparam logic [2:0] CAUSE_TIMEOUT  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_PRECHARGE_END = 3'd0;
  localparam logic [2:0] REG_FAST_END      = 3'd1;
  localparam logic [2:0] REG_FULL_VOLT     = 3'd2;
  localparam logic [2:0] REG_CHG_NOMINAL   = 3'd3;
  localparam logic [2:0] REG_CUR_LIMIT     = 3'd4;
  localparam logic [2:0] REG_HOT_TEMP      = 3'd5;
  localparam logic [2:0] REG_HOT_RELEASE   = 3'd6;
  localparam logic [2:0] REG_CHG_TIMEOUT   = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration reset values.
  localparam logic [15:0] RST_PRECHARGE_END = 16'd3000;
  localparam logic [15:0] RST_FAST_END      = 16'd4150;
  localparam logic [15:0] RST_FULL_VOLT     = 16'd4200;
  localparam logic [15:0] RST_CHG_NOMINAL   = 16'd42000;
  localparam logic [15:0] RST_CUR_LIMIT     = 16'd5000;
  localparam logic [7:0]  RST_HOT_TEMP      = 8'd45;
  localparam logic [7:0]  RST_HOT_RELEASE   = 8'd40;
  localparam logic [31:0] RST_CHG_TIMEOUT   = 32'd14400000;

  // Fixed timing and filter constants.
  localparam logic [31:0] PRECHARGE_TIMEOUT_MS = 32'd60000;
  localparam logic [31:0] COOL_WAIT_MS         = 32'd600000;
  localparam logic [31:0] FULL_HOLD_MS         = 32'd600000;
  localparam logic [16:0] WINDOW_MV            = 17'd3000;
  localparam logic [3:0]  HEAT_LIMIT           = 4'd10;
  localparam logic [3:0]  VOLT_LIMIT           = 4'd10;
  localparam logic [2:0]  FAULT_LIMIT          = 3'd5;
  localparam logic [15:0] EVENTS_MAX           = 16'hffff;

  // The pulse period of 1000 ms is split as 8 * 125: the low three bits of the
  // timestamp pass through and the rest is reduced modulo 125 by a reciprocal.
  localparam logic [29:0] PULSE_RECIP   = 30'd549755813;  // floor(2^36 / 125)
  localparam int          RECIP_SHIFT   = 36;
  localparam logic [7:0]  PULSE_SUB     = 8'd125;
  localparam logic [9:0]  PULSE_ON_MS   = 10'd100;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic [15:0] cell_min_mv;
    logic [15:0] cell_max_mv;
    logic [15:0] charger_mv;
    logic [15:0] charger_ma;
    logic [7:0]  temperature;
  } in_item_t;

  typedef struct packed {
    logic        precharge_switch;
    logic        charge_switch;
    logic [2:0]  phase;
    logic        shutdown;
    logic [2:0]  shutdown_cause;
    logic [15:0] overheat_events;
  } out_item_t;

endpackage

// File: rtl/core/battery_charge_supervisor.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_data   (bcs_pkg::in_item_t)
// out_      output     out_valid / out_stall out_data  (bcs_pkg::out_item_t)
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// A request passes through the input stage, where the pulse timer reciprocal
// product is formed, and then through the result register.
// The supervisor state updates as a request moves into the result register,
// so a new request is accepted every cycle while the output is not stalled.
// Synchronous active-low reset restores register defaults and the halted state.
// A stalled result holds the pipeline; a request can still enter an empty stage.
module battery_charge_supervisor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bcs_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bcs_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [bcs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bcs_pkg::*;

  // Configuration registers.
  logic [15:0] pre_end_r, fast_end_r, full_volt_r, chg_nom_r, cur_limit_r;
  logic [7:0]  hot_temp_r, hot_rel_r;
  logic [31:0] chg_timeout_r;

  // Pipeline control and payload.
  logic        s_valid_r, out_valid_r;
  in_item_t    s_data_r;
  logic [22:0] q_r;
  out_item_t   out_data_r;
  logic        out_ld, s_ld, adv;
  logic [58:0] prod;

  // Supervisor state.
  logic        halted_r, halted_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic        precharging_r, precharging_nxt;
  logic        fast_r, fast_nxt;
  logic [3:0]  vcount_r, vcount_nxt;
  logic        full_r, full_nxt;
  logic [31:0] full_time_r, full_time_nxt;
  logic [2:0]  vfc_r, vfc_nxt;
  logic [2:0]  afc_r, afc_nxt;
  logic [3:0]  heat_r, heat_nxt;
  logic        hot_r, hot_nxt;
  logic [31:0] hot_time_r, hot_time_nxt;
  logic [15:0] events_r, events_nxt;
  logic        pre_lvl_r, pre_lvl_nxt;
  logic        chg_lvl_r, chg_lvl_nxt;

  // Combinational helpers.
  logic [2:0]  cause;
  logic [2:0]  phase;
  logic [29:0] mul125, rem30;
  logic [7:0]  rem8;
  logic [6:0]  rem7;
  logic        pulse_on;
  logic [7:0]  thr;
  logic        hot_bad, volt_bad, amp_bad;
  logic [16:0] win_lo, win_hi;
  logic [3:0]  vinc;

  assign out_ld   = !out_valid_r || !out_stall;
  assign s_ld     = !s_valid_r || out_ld;
  assign adv      = s_valid_r && out_ld;
  assign in_stall = !s_ld;

  assign prod = {30'd0, in_data.now_ms[31:3]} * {29'd0, PULSE_RECIP};

  // Reduce now/8 modulo 125; the truncated reciprocal leaves the remainder
  // below 250, so one conditional subtract finishes it.
  assign mul125 = {q_r, 7'd0} - {5'd0, q_r, 2'd0} + {7'd0, q_r};
  assign rem30  = {1'b0, s_data_r.now_ms[31:3]} - mul125;
  assign rem8   = (rem30[7:0] >= PULSE_SUB) ? rem30[7:0] - PULSE_SUB : rem30[7:0];
  assign rem7   = rem8[6:0];
  assign pulse_on = {rem7, s_data_r.now_ms[2:0]} < PULSE_ON_MS;

  assign thr      = hot_r ? hot_rel_r : hot_temp_r;
  assign hot_bad  = $signed(s_data_r.temperature) > $signed(thr);
  assign win_lo   = ({1'b0, chg_nom_r} > WINDOW_MV) ? {1'b0, chg_nom_r} - WINDOW_MV : 17'd0;
  assign win_hi   = {1'b0, chg_nom_r} + WINDOW_MV;
  assign volt_bad = ({1'b0, s_data_r.charger_mv} < win_lo) ||
                    ({1'b0, s_data_r.charger_mv} > win_hi);
  assign amp_bad  = s_data_r.charger_ma > cur_limit_r;
  assign vinc     = vcount_r + 4'd1;

  always_comb begin
    halted_nxt      = halted_r;
    start_time_nxt  = start_time_r;
    precharging_nxt = precharging_r;
    fast_nxt        = fast_r;
    vcount_nxt      = vcount_r;
    full_nxt        = full_r;
    full_time_nxt   = full_time_r;
    vfc_nxt         = vfc_r;
    afc_nxt         = afc_r;
    heat_nxt        = heat_r;
    hot_nxt         = hot_r;
    hot_time_nxt    = hot_time_r;
    events_nxt      = events_r;
    pre_lvl_nxt     = pre_lvl_r;
    chg_lvl_nxt     = chg_lvl_r;
    cause           = CAUSE_NONE;

    if (s_data_r.operation == OP_START) begin
      halted_nxt      = 1'b0;
      start_time_nxt  = s_data_r.now_ms;
      precharging_nxt = 1'b1;
      fast_nxt        = 1'b1;
      vcount_nxt      = 4'd0;
      full_nxt        = 1'b0;
      full_time_nxt   = 32'd0;
      vfc_nxt         = 3'd0;
      afc_nxt         = 3'd0;
      heat_nxt        = 4'd0;
      hot_nxt         = 1'b0;
      hot_time_nxt    = 32'd0;
      pre_lvl_nxt     = 1'b0;
      chg_lvl_nxt     = 1'b1;
    end else if (!halted_r) begin
      // Over-temperature filter with hysteresis.
      if (hot_bad) begin
        if (heat_r < HEAT_LIMIT) heat_nxt = heat_r + 4'd1;
      end else if (heat_r != 4'd0) begin
        heat_nxt = heat_r - 4'd1;
      end
      if (heat_nxt == HEAT_LIMIT && !hot_r) begin
        if (events_r != EVENTS_MAX) events_nxt = events_r + 16'd1;
        hot_time_nxt = s_data_r.now_ms;
        hot_nxt      = 1'b1;
        chg_lvl_nxt  = 1'b0;
      end else if (heat_nxt == HEAT_LIMIT) begin
        if (s_data_r.now_ms - hot_time_r > COOL_WAIT_MS) cause = CAUSE_COOLING;
      end else if (heat_nxt == 4'd0) begin
        chg_lvl_nxt = 1'b1;
        hot_nxt     = 1'b0;
      end

      if (cause == CAUSE_NONE) begin
        if (precharging_r && (s_data_r.cell_min_mv > pre_end_r ||
            s_data_r.now_ms - start_time_r > PRECHARGE_TIMEOUT_MS)) begin
          precharging_nxt = 1'b0;
          pre_lvl_nxt     = 1'b1;
        end

        if (fast_r) begin
          if (s_data_r.cell_max_mv > fast_end_r) begin
            vcount_nxt = vinc;
            if (vinc > VOLT_LIMIT) begin
              vcount_nxt = 4'd0;
              fast_nxt   = 1'b0;
            end
          end else if (vcount_r != 4'd0) begin
            vcount_nxt = vcount_r - 4'd1;
          end
        end else if (!full_r) begin
          chg_lvl_nxt = pulse_on;
          if (s_data_r.cell_max_mv > full_volt_r) begin
            vcount_nxt = vinc;
            if (vinc > VOLT_LIMIT) begin
              full_time_nxt = s_data_r.now_ms;
              chg_lvl_nxt   = 1'b0;
              full_nxt      = 1'b1;
            end
          end else if (vcount_r != 4'd0) begin
            vcount_nxt = vcount_r - 4'd1;
          end
        end else if (s_data_r.now_ms - full_time_r > FULL_HOLD_MS) begin
          cause = CAUSE_FULL;
        end
      end

      if (cause == CAUSE_NONE) begin
        if (volt_bad) begin
          if (vfc_r < FAULT_LIMIT) vfc_nxt = vfc_r + 3'd1;
        end else if (vfc_r != 3'd0) begin
          vfc_nxt = vfc_r - 3'd1;
        end
        if (vfc_nxt == FAULT_LIMIT) cause = CAUSE_CHG_VOLT;
      end

      if (cause == CAUSE_NONE) begin
        if (amp_bad) begin
          if (afc_r < FAULT_LIMIT) afc_nxt = afc_r + 3'd1;
        end else if (afc_r != 3'd0) begin
          afc_nxt = afc_r - 3'd1;
        end
        if (afc_nxt == FAULT_LIMIT) cause = CAUSE_CURRENT;
      end

      if (cause == CAUSE_NONE) begin
        if (s_data_r.now_ms - start_time_r > chg_timeout_r) cause = CAUSE_TIMEOUT;
      end

      if (cause != CAUSE_NONE) begin
        halted_nxt  = 1'b1;
        pre_lvl_nxt = 1'b0;
        chg_lvl_nxt = 1'b0;
      end
    end

    if (halted_nxt)           phase = PHASE_HALTED;
    else if (precharging_nxt) phase = PHASE_PRECHARGE;
    else if (fast_nxt)        phase = PHASE_FAST;
    else if (full_nxt)        phase = PHASE_FULL_HOLD;
    else                      phase = PHASE_TRICKLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_end_r     <= RST_PRECHARGE_END;
      fast_end_r    <= RST_FAST_END;
      full_volt_r   <= RST_FULL_VOLT;
      chg_nom_r     <= RST_CHG_NOMINAL;
      cur_limit_r   <= RST_CUR_LIMIT;
      hot_temp_r    <= RST_HOT_TEMP;
      hot_rel_r     <= RST_HOT_RELEASE;
      chg_timeout_r <= RST_CHG_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRECHARGE_END: pre_end_r     <= cfg_data[15:0];
        REG_FAST_END:      fast_end_r    <= cfg_data[15:0];
        REG_FULL_VOLT:     full_volt_r   <= cfg_data[15:0];
        REG_CHG_NOMINAL:   chg_nom_r     <= cfg_data[15:0];
        REG_CUR_LIMIT:     cur_limit_r   <= cfg_data[15:0];
        REG_HOT_TEMP:      hot_temp_r    <= cfg_data[7:0];
        REG_HOT_RELEASE:   hot_rel_r     <= cfg_data[7:0];
        REG_CHG_TIMEOUT:   chg_timeout_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s_ld)   s_valid_r   <= in_valid;
      if (out_ld) out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ld && in_valid) begin
      s_data_r <= in_data;
      q_r      <= prod[RECIP_SHIFT+22:RECIP_SHIFT];
    end
    if (adv) begin
      out_data_r.precharge_switch <= pre_lvl_nxt;
      out_data_r.charge_switch    <= chg_lvl_nxt;
      out_data_r.phase            <= phase;
      out_data_r.shutdown         <= (cause != CAUSE_NONE);
      out_data_r.shutdown_cause   <= cause;
      out_data_r.overheat_events  <= events_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r      <= 1'b1;
      start_time_r  <= 32'd0;
      precharging_r <= 1'b1;
      fast_r        <= 1'b1;
      vcount_r      <= 4'd0;
      full_r        <= 1'b0;
      full_time_r   <= 32'd0;
      vfc_r         <= 3'd0;
      afc_r         <= 3'd0;
      heat_r        <= 4'd0;
      hot_r         <= 1'b0;
      hot_time_r    <= 32'd0;
      events_r      <= 16'd0;
      pre_lvl_r     <= 1'b0;
      chg_lvl_r     <= 1'b0;
    end else if (adv) begin
      halted_r      <= halted_nxt;
      start_time_r  <= start_time_nxt;
      precharging_r <= precharging_nxt;
      fast_r        <= fast_nxt;
      vcount_r      <= vcount_nxt;
      full_r        <= full_nxt;
      full_time_r   <= full_time_nxt;
      vfc_r         <= vfc_nxt;
      afc_r         <= afc_nxt;
      heat_r        <= heat_nxt;
      hot_r         <= hot_nxt;
      hot_time_r    <= hot_time_nxt;
      events_r      <= events_nxt;
      pre_lvl_r     <= pre_lvl_nxt;
      chg_lvl_r     <= chg_lvl_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_halt_switches_off: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (!pre_lvl_r && !chg_lvl_r))
    else $error("switch driven while halted");

  a_filters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (heat_r <= HEAT_LIMIT) && (vfc_r <= FAULT_LIMIT) && (afc_r <= FAULT_LIMIT))
    else $error("filter count out of range");

  a_shutdown_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.shutdown) |-> (out_data_r.phase == PHASE_HALTED))
    else $error("shutdown reported without halted phase");

  a_cause_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.shutdown == (out_data_r.shutdown_cause != CAUSE_NONE)))
    else $error("shutdown flag and cause disagree");
`endif

endmodule

// File: tb/sv/bcs_tb_pkg.sv
`timescale 1ns / 1ps

package bcs_tb_pkg;
  import bcs_pkg::*;

  localparam int PULSE_PERIOD_MS = 1000;

  typedef struct packed {
    logic [15:0] precharge_end;
    logic [15:0] fast_end;
    logic [15:0] full_volt;
    logic [15:0] chg_nominal;
    logic [15:0] cur_limit;
    logic [7:0]  hot_temp;
    logic [7:0]  hot_release;
    logic [31:0] chg_timeout;
  } cfg_set_t;

  class charge_tracker;
    logic [15:0]       precharge_end;
    logic [15:0]       fast_end;
    logic [15:0]       full_volt;
    logic [15:0]       chg_nominal;
    logic [15:0]       cur_limit;
    logic signed [7:0] hot_temp;
    logic signed [7:0] hot_release;
    logic [31:0]       chg_timeout;

    bit                halted;
    logic [31:0]       start_time;
    bit                precharging;
    bit                fast_phase;
    logic [3:0]        voltage_count;
    bit                full_reached;
    logic [31:0]       full_time;
    logic [3:0]        volt_faults;
    logic [3:0]        amp_faults;
    logic [3:0]        heat_count;
    bit                overheated;
    logic [31:0]       overheat_time;
    logic [15:0]       heat_events;
    bit                precharge_on;
    bit                charge_on;

    out_item_t         pending_results[$];
    int                mismatches;
    int                requests;
    int                results;
    int                shutdowns[6];

    function new();
      precharge_end = RST_PRECHARGE_END;
      fast_end      = RST_FAST_END;
      full_volt     = RST_FULL_VOLT;
      chg_nominal   = RST_CHG_NOMINAL;
      cur_limit     = RST_CUR_LIMIT;
      hot_temp      = RST_HOT_TEMP;
      hot_release   = RST_HOT_RELEASE;
      chg_timeout   = RST_CHG_TIMEOUT;
      clear_session();
      halted       = 1'b1;
      heat_events  = '0;
      precharge_on = 1'b0;
      charge_on    = 1'b0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_PRECHARGE_END: precharge_end = value[15:0];
        REG_FAST_END:      fast_end      = value[15:0];
        REG_FULL_VOLT:     full_volt     = value[15:0];
        REG_CHG_NOMINAL:   chg_nominal   = value[15:0];
        REG_CUR_LIMIT:     cur_limit     = value[15:0];
        REG_HOT_TEMP:      hot_temp      = value[7:0];
        REG_HOT_RELEASE:   hot_release   = value[7:0];
        REG_CHG_TIMEOUT:   chg_timeout   = value;
        default: ;
      endcase
    endfunction

    // Resets the session state; the overheat event count, halted flag, switch levels and register copies are kept.
    function void clear_session();
      start_time    = '0;
      precharging   = 1'b1;
      fast_phase    = 1'b1;
      voltage_count = '0;
      full_reached  = 1'b0;
      full_time     = '0;
      volt_faults   = '0;
      amp_faults    = '0;
      heat_count    = '0;
      overheated    = 1'b0;
      overheat_time = '0;
    endfunction

    function logic [3:0] step_filter(logic [3:0] count, bit bad, logic [3:0] limit);
      if (bad) return (count < limit) ? count + 4'd1 : count;
      return (count > 0) ? count - 4'd1 : count;
    endfunction

    // Runs the checks of one pass in order; the first shutdown ends the pass.
    function logic [2:0] run_checks(in_item_t req);
      logic signed [7:0] thr;
      int                lo;
      int                hi;
      thr = overheated ? hot_release : hot_temp;
      heat_count = step_filter(heat_count, signed'(req.temperature) > thr, HEAT_LIMIT);
      if (heat_count == HEAT_LIMIT && !overheated) begin
        if (heat_events < EVENTS_MAX) heat_events++;
        overheat_time = req.now_ms;
        overheated    = 1'b1;
        charge_on     = 1'b0;
      end else if (heat_count == HEAT_LIMIT) begin
        if (req.now_ms - overheat_time > COOL_WAIT_MS) return CAUSE_COOLING;
      end else if (heat_count == 0) begin
        charge_on  = 1'b1;
        overheated = 1'b0;
      end

      if (precharging && (req.cell_min_mv > precharge_end ||
                          req.now_ms - start_time > PRECHARGE_TIMEOUT_MS)) begin
        precharging  = 1'b0;
        precharge_on = 1'b1;
      end

      if (fast_phase) begin
        if (req.cell_max_mv > fast_end) begin
          voltage_count++;
          if (voltage_count > VOLT_LIMIT) begin
            voltage_count = '0;
            fast_phase    = 1'b0;
          end
        end else if (voltage_count > 0) begin
          voltage_count--;
        end
      end else if (!full_reached) begin
        charge_on = (req.now_ms % PULSE_PERIOD_MS) < 32'(PULSE_ON_MS);
        if (req.cell_max_mv > full_volt) begin
          voltage_count++;
          if (voltage_count > VOLT_LIMIT) begin
            full_time    = req.now_ms;
            charge_on    = 1'b0;
            full_reached = 1'b1;
          end
        end else if (voltage_count > 0) begin
          voltage_count--;
        end
      end else if (req.now_ms - full_time > FULL_HOLD_MS) begin
        return CAUSE_FULL;
      end

      // The lower window edge stops at zero rather than wrapping.
      lo = (int'(chg_nominal) > int'(WINDOW_MV)) ? int'(chg_nominal) - int'(WINDOW_MV) : 0;
      hi = int'(chg_nominal) + int'(WINDOW_MV);
      volt_faults = step_filter(volt_faults,
                                int'(req.charger_mv) < lo || int'(req.charger_mv) > hi,
                                4'(FAULT_LIMIT));
      if (volt_faults == 4'(FAULT_LIMIT)) return CAUSE_CHG_VOLT;

      amp_faults = step_filter(amp_faults, req.charger_ma > cur_limit, 4'(FAULT_LIMIT));
      if (amp_faults == 4'(FAULT_LIMIT)) return CAUSE_CURRENT;

      if (req.now_ms - start_time > chg_timeout) return CAUSE_TIMEOUT;
      return CAUSE_NONE;
    endfunction

    function out_item_t predict_pass(in_item_t req);
      logic [2:0] cause;
      out_item_t  res;
      cause = CAUSE_NONE;
      if (req.operation == OP_START) begin
        clear_session();
        start_time   = req.now_ms;
        precharge_on = 1'b0;
        charge_on    = 1'b1;
        halted       = 1'b0;
      end else if (!halted) begin
        cause = run_checks(req);
        if (cause != CAUSE_NONE) begin
          halted       = 1'b1;
          precharge_on = 1'b0;
          charge_on    = 1'b0;
          shutdowns[cause]++;
        end
      end

      if (halted)            res.phase = PHASE_HALTED;
      else if (precharging)  res.phase = PHASE_PRECHARGE;
      else if (fast_phase)   res.phase = PHASE_FAST;
      else if (full_reached) res.phase = PHASE_FULL_HOLD;
      else                   res.phase = PHASE_TRICKLE;
      res.precharge_switch = precharge_on;
      res.charge_switch    = charge_on;
      res.shutdown         = (cause != CAUSE_NONE);
      res.shutdown_cause   = cause;
      res.overheat_events  = heat_events;
      return res;
    endfunction

    function void accept_request(in_item_t req);
      requests++;
      pending_results.push_back(predict_pass(req));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch: %s", what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                  results, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting", results));
        return;
      end
      want = pending_results.pop_front();
      compare_field("precharge_switch", 16'(got.precharge_switch),
                    16'(want.precharge_switch));
      compare_field("charge_switch", 16'(got.charge_switch), 16'(want.charge_switch));
      compare_field("phase", 16'(got.phase), 16'(want.phase));
      compare_field("shutdown", 16'(got.shutdown), 16'(want.shutdown));
      compare_field("shutdown_cause", 16'(got.shutdown_cause), 16'(want.shutdown_cause));
      compare_field("overheat_events", got.overheat_events, want.overheat_events);
    endtask
  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bcs_pkg::*;
  import bcs_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int NUM_REG_SETS = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_WAIT     = 16;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  bit                     no_idle     = 1'b0;
  int                     idle_cycles = 0;
  int                     reg_sets    = 0;
  charge_tracker          sb;

  battery_charge_supervisor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [15:0] clamp16(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hffff : 16'(v);
  endfunction

  function automatic logic [7:0] clamp8(int v);
    return (v < -128) ? 8'h80 : (v > 127) ? 8'h7f : 8'(v);
  endfunction

  function automatic logic [15:0] near16(logic [15:0] thr, bit above);
    if (above) return clamp16(int'(thr) + int'($urandom_range(1, 400)));
    return clamp16(int'(thr) - int'($urandom_range(0, 400)));
  endfunction

  task automatic send_request(in_item_t req);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.accept_request(req);
  endtask

  initial begin : result_sink
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = pick_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic load_regs(cfg_set_t s);
    cfg_we <= 1'b1;
    put_reg(REG_PRECHARGE_END, {16'd0, s.precharge_end});
    put_reg(REG_FAST_END,      {16'd0, s.fast_end});
    put_reg(REG_FULL_VOLT,     {16'd0, s.full_volt});
    put_reg(REG_CHG_NOMINAL,   {16'd0, s.chg_nominal});
    put_reg(REG_CUR_LIMIT,     {16'd0, s.cur_limit});
    put_reg(REG_HOT_TEMP,      {24'd0, s.hot_temp});
    put_reg(REG_HOT_RELEASE,   {24'd0, s.hot_release});
    put_reg(REG_CHG_TIMEOUT,   s.chg_timeout);
    cfg_we <= 1'b0;
    reg_sets++;
  endtask

  // Registers change only once every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_set_t choose_cfg(int kind);
    cfg_set_t s;
    s.precharge_end = 16'($urandom_range(2500, 3300));
    s.fast_end      = 16'($urandom_range(3900, 4200));
    s.full_volt     = 16'($urandom_range(4000, 4300));
    s.chg_nominal   = 16'($urandom);
    s.cur_limit     = 16'($urandom);
    s.hot_temp      = 8'($urandom);
    s.hot_release   = 8'($urandom);
    s.chg_timeout   = $urandom_range(100000, 20000000);
    case (kind)
      0: s = '{RST_PRECHARGE_END, RST_FAST_END, RST_FULL_VOLT, RST_CHG_NOMINAL,
               RST_CUR_LIMIT, RST_HOT_TEMP, RST_HOT_RELEASE, RST_CHG_TIMEOUT};
      1: s = '0;
      2: begin
        s = '1;
        s.hot_temp    = 8'h7f;
        s.hot_release = 8'h7f;
      end
      3: begin
        s.chg_nominal = 16'd0;
        s.hot_temp    = 8'h80;
        s.hot_release = 8'h7f;
        s.chg_timeout = '1;
      end
      4: begin
        s.chg_nominal = 16'd2999 + 16'($urandom_range(0, 1));
        s.hot_temp    = 8'h7f;
        s.hot_release = 8'h80;
        s.chg_timeout = $urandom;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic directed_checks();
    logic [31:0] t;
    // A check before any start reports the halted phase with both switches off.
    send_request(in_item_t'{OP_CHECK, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff,
                            16'hffff, 8'h7f});
    t = 32'hffff_ff00;
    send_request(in_item_t'{OP_START, t, 16'h0, 16'h0, 16'h0, 16'h0, 8'h80});
    // Ten hot passes across the timestamp wrap raise the overheat flag.
    repeat (10) begin
      t += 32'd100;
      send_request(in_item_t'{OP_CHECK, t, 16'hffff, 16'h0, 16'd42000, 16'h0, 8'h7f});
    end
    // The cooling deadline expires; the bad charger voltage is never looked at.
    t += 32'd700000;
    send_request(in_item_t'{OP_CHECK, t, 16'hffff, 16'h0, 16'h0, 16'h0, 8'h7f});
    send_request(in_item_t'{OP_CHECK, t + 32'd1, 16'h0, 16'hffff, 16'd42000, 16'h0, 8'h0});
    // Precharge ends on its timeout, then the total charge timeout fires.
    send_request(in_item_t'{OP_START, 32'd1000, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0});
    send_request(in_item_t'{OP_CHECK, 32'd61001, 16'h0, 16'hffff, 16'd39000, 16'd5000,
                            8'h80});
    send_request(in_item_t'{OP_CHECK, 32'd14402001, 16'h0, 16'h0, 16'd45000, 16'd0, 8'h0});
    // Voltage and current faults mature together; the voltage one is reported.
    send_request(in_item_t'{OP_START, 32'd0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0});
    repeat (5)
      send_request(in_item_t'{OP_CHECK, 32'd10, 16'h0, 16'h0, 16'd45001, 16'hffff, 8'h0});
  endtask

  // One charge cycle: cells rise through the thresholds while time advances,
  // with optional hot stretches, charger faults and stray requests mixed in.
  task automatic run_session();
    int          n;
    int          kp;
    int          kf;
    int          kt;
    int          h0;
    int          h1;
    int          held;
    int          temp;
    int          r;
    int          off;
    bit          faulty;
    bit          above;
    logic [31:0] t;
    logic [15:0] cmin;
    logic [15:0] cmax;
    logic [15:0] cmv;
    logic [15:0] cma;
    n       = $urandom_range(20, 80);
    kp      = $urandom_range(0, 15);
    kf      = kp + $urandom_range(0, 12);
    kt      = kf + 11 + $urandom_range(0, 10);
    h0      = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : n;
    h1      = h0 + $urandom_range(8, 25);
    faulty  = ($urandom_range(0, 5) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    t = ($urandom_range(0, 4) == 0) ? 32'hffff_ffff - $urandom_range(0, 300000) : $urandom;
    send_request(in_item_t'{OP_START, t, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 8'($urandom)});
    held = 0;
    for (int k = 0; k < n && held < 3; k++) begin
      if (sb.halted) held++;
      if ($urandom_range(0, 29) == 0) begin
        send_request(in_item_t'{1'($urandom), $urandom, 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 8'($urandom)});
        continue;
      end

      r = $urandom_range(0, 59);
      if (r < 5)       t += $urandom_range(50000, 700000);
      else if (r == 5) t += $urandom;
      else             t += $urandom_range(1, 3000);

      above = (k >= kp);
      if ($urandom_range(0, 9) == 0) above = !above;
      cmin = near16(sb.precharge_end, above);
      above = (k >= kf);
      if ($urandom_range(0, 9) == 0) above = !above;
      cmax = near16((k >= kt) ? sb.full_volt : sb.fast_end, above);

      r = $urandom_range(0, 99);
      if (r < (faulty ? 50 : 6)) begin
        cmv = 16'($urandom);
      end else if (r < (faulty ? 54 : 10)) begin
        off = 3000 + $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 0) off = -off;
        cmv = clamp16(int'(sb.chg_nominal) + off);
      end else begin
        cmv = clamp16(int'(sb.chg_nominal) + int'($urandom_range(0, 6000)) - 3000);
      end

      if ($urandom_range(0, 99) < (faulty ? 50 : 8)) cma = near16(sb.cur_limit, 1'b1);
      else cma = 16'($urandom_range(0, sb.cur_limit));

      if (k >= h0 && k < h1) begin
        temp = int'(sb.hot_temp) + int'($urandom_range(1, 20));
      end else begin
        case ($urandom_range(0, 9))
          0: temp = int'($urandom_range(0, 255)) - 128;
          1: temp = int'(sb.hot_release) + int'($urandom_range(0, 10)) - 5;
          default: temp = int'(sb.hot_release) - int'($urandom_range(1, 30));
        endcase
      end

      send_request(in_item_t'{OP_CHECK, t, cmin, cmax, cmv, cma, clamp8(temp)});
    end
  endtask

  initial begin : stimulus
    int base;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    base = sb.requests;
    for (int ph = 0; ph < NUM_REG_SETS; ph++) begin
      settle();
      load_regs(choose_cfg(ph));
      while (sb.requests < base + (ph + 1) * RANDOM_ITEMS / NUM_REG_SETS) run_session();
    end
    settle();
    $display("Covered %0d requests and %0d results over %0d register settings.",
             sb.requests, sb.results, reg_sets);
    $display("Shutdowns: cooling %0d, full hold %0d, charger volt %0d, current %0d, timeout %0d.",
             sb.shutdowns[CAUSE_COOLING], sb.shutdowns[CAUSE_FULL],
             sb.shutdowns[CAUSE_CHG_VOLT], sb.shutdowns[CAUSE_CURRENT],
             sb.shutdowns[CAUSE_TIMEOUT]);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: battery_charge_supervisor.f
rtl/core/bcs_pkg.sv
rtl/core/battery_charge_supervisor.sv
tb/sv/bcs_tb_pkg.sv
tb/sv/tb_top.sv
